// ===== design/multilevel_queue_rr_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// multilevel_queue_rr_scheduler_defines
// assertion macros for the scheduler
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_QUEUE_RR_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_QUEUE_RR_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define MLQ_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("mlq check failed");
`define MLQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("mlq check failed");
`else
`define MLQ_ASSERT_IMPL(label, clk, rst, a, c)
`define MLQ_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== design/mlq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlq_pkg
// shared widths and types of the multilevel queue scheduler
// ----------------------------------------------------------------------------
package mlq_pkg;
  localparam int Procs     = 16;
  localparam int Levels    = 8;
  localparam int TimeBits  = 32;
  localparam int SlotBits  = 4;
  localparam int LevelBits = 3;

  typedef enum logic {OP_ARRIVE = 1'b0, OP_TICK = 1'b1} op_t;

  typedef struct packed {
    logic                operation;
    logic [3:0]          proc_slot;
    logic [3:0]          level;
    logic [15:0]         burst;
  } in_word_t;

  typedef struct packed {
    logic                run_valid;
    logic [3:0]          run_slot;
    logic [31:0]         time_now;
    logic                done_valid;
    logic [3:0]          done_slot;
    logic [31:0]         done_end_time;
    logic [31:0]         done_wait;
    logic [31:0]         done_first_run;
  } out_word_t;
endpackage

// ===== design/mlq_if.sv =====
// ----------------------------------------------------------------------------
// mlq_in_if / mlq_out_if
// valid/ready channels of the scheduler
// ----------------------------------------------------------------------------
interface mlq_in_if;
  logic             valid;
  logic             ready;
  mlq_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mlq_out_if;
  logic              valid;
  logic              ready;
  mlq_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/multilevel_queue_rr_scheduler.sv =====
// ----------------------------------------------------------------------------
// multilevel_queue_rr_scheduler
// fixed priority levels with round robin inside each level
// ----------------------------------------------------------------------------
// path: a tick word passes the input register, then the core result register
// throughput: one word per cycle while the output side keeps up
// the input register and the scheduler state update set that figure
// reset: synchronous, clears time, cpu state, queues and quantum (to 4)
// a one-entry skid register holds a stalled result, the core waits until it drains
module multilevel_queue_rr_scheduler (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [7:0]  cfg_wdata,
  mlq_in_if.sink     in_ch,
  mlq_out_if.source  out_ch
);
`include "multilevel_queue_rr_scheduler_defines.svh"

  logic [7:0]         slice_len;
  logic               in_valid;        // input register holds a word
  mlq_pkg::in_word_t  in_word;
  logic               go;
  mlq_pkg::out_word_t core_res;
  logic               core_valid;
  logic               cpu_busy;
  logic               skid_valid;
  mlq_pkg::out_word_t skid_word;

  // core fires when there is room: output free or being drained
  // input register consumed by core when the result slot can take it
  assign go = in_valid && !(out_ch.valid && !out_ch.ready && core_valid) && !skid_valid;
  assign in_ch.ready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_len <= 8'd4;
      in_valid <= 1'b0;
    end else begin
      if (cfg_we) slice_len <= cfg_wdata;
      if (in_ch.ready) in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_word <= in_ch.data;
  end

  mlq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .word      (in_word),
    .quantum   (slice_len),
    .res       (core_res),
    .res_valid (core_valid),
    .cpu_busy_o(cpu_busy)
  );

  // skid holds a core result that arrived while the output stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ch.ready) skid_valid <= 1'b0;
    end else if (core_valid && !out_ch.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && core_valid && !out_ch.ready) skid_word <= core_res;
  end

  assign out_ch.valid = skid_valid || core_valid;
  assign out_ch.data  = skid_valid ? skid_word : core_res;

  `MLQ_ASSERT_IMPL(a_skid_no_core, clk, rst, skid_valid, !core_valid)
  `MLQ_ASSERT_NEXT(a_stall_holds, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `MLQ_ASSERT_IMPL(a_run_busy, clk, rst, core_valid && core_res.done_valid, core_res.run_valid)
  `MLQ_ASSERT_IMPL(a_idle_slot, clk, rst, core_valid && !core_res.run_valid, core_res.run_slot == '0 && !cpu_busy)
endmodule

// ===== design/mlq_core.sv =====
// ----------------------------------------------------------------------------
// mlq_core
// scheduler state and single pass update per registered word
// ----------------------------------------------------------------------------
module mlq_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  mlq_pkg::in_word_t  word,
  input  logic [7:0]         quantum,
  output mlq_pkg::out_word_t res,
  output logic               res_valid,
  output logic               cpu_busy_o
);
  localparam int P = mlq_pkg::Procs;
  localparam int L = mlq_pkg::Levels;
  localparam int SB = mlq_pkg::SlotBits;
  localparam int LB = mlq_pkg::LevelBits;
  localparam int TB = mlq_pkg::TimeBits;

  logic [TB-1:0] current_time, current_time_next;
  logic          cpu_busy, cpu_busy_next;
  logic [SB-1:0] cpu_slot, cpu_slot_next;
  logic [7:0]    quantum_used, quantum_used_next;
  logic [15:0]   remaining_burst [P], remaining_burst_next [P];
  logic [TB-1:0] wait_count [P], wait_count_next [P];
  logic [TB-1:0] first_run_time [P], first_run_time_next [P];
  logic          has_run [P], has_run_next [P];
  logic [LB-1:0] slot_level [P], slot_level_next [P];
  logic [P-1:0]  in_ready, in_ready_next;
  logic [SB-1:0] next_in_level [P], next_in_level_next [P];
  logic [SB-1:0] level_head [L], level_head_next [L];
  logic [SB-1:0] level_tail [L], level_tail_next [L];
  logic [L-1:0]  level_nonempty, level_nonempty_next;
  mlq_pkg::out_word_t res_next;

  always_comb begin
    logic [SB-1:0] s;
    logic [LB-1:0] lv;
    logic          found, busy, requeue;
    logic [15:0]   rb;
    logic [7:0]    qu;
    logic [P-1:0]  waiting;
    current_time_next = current_time;
    cpu_busy_next = cpu_busy;
    cpu_slot_next = cpu_slot;
    quantum_used_next = quantum_used;
    remaining_burst_next = remaining_burst;
    wait_count_next = wait_count;
    first_run_time_next = first_run_time;
    has_run_next = has_run;
    slot_level_next = slot_level;
    in_ready_next = in_ready;
    next_in_level_next = next_in_level;
    level_head_next = level_head;
    level_tail_next = level_tail;
    level_nonempty_next = level_nonempty;
    res_next = '0;
    s = word.proc_slot;
    lv = LB'(word.level - 4'd1);
    found = 1'b0;
    busy = cpu_busy;
    requeue = 1'b0;
    rb = '0;
    qu = quantum_used;
    waiting = in_ready;
    if (word.operation == mlq_pkg::OP_ARRIVE) begin
      if (word.burst != 16'd0 && word.level != 4'd0 && word.level <= 4'(L) &&
          !in_ready[s] && !(cpu_busy && cpu_slot == s)) begin
        remaining_burst_next[s] = word.burst;
        wait_count_next[s] = '0;
        first_run_time_next[s] = '0;
        has_run_next[s] = 1'b0;
        slot_level_next[s] = lv;
        if (level_nonempty[lv]) next_in_level_next[level_tail[lv]] = s;
        else begin
          level_head_next[lv] = s;
          level_nonempty_next[lv] = 1'b1;
        end
        level_tail_next[lv] = s;
        in_ready_next[s] = 1'b1;
      end
    end else begin
      s = cpu_slot;
      if (!cpu_busy) begin
        // priority pick of the non-empty level with the lowest index
        for (int i = L - 1; i >= 0; i--) begin
          if (level_nonempty[i]) begin
            found = 1'b1;
            lv = LB'(i);
          end
        end
        if (found) begin
          s = level_head[lv];
          if (s == level_tail[lv]) level_nonempty_next[lv] = 1'b0;
          else level_head_next[lv] = next_in_level[s];
          waiting[s] = 1'b0;
          busy = 1'b1;
          qu = '0;
          if (!has_run[s]) begin
            has_run_next[s] = 1'b1;
            first_run_time_next[s] = current_time;
          end
        end
      end
      res_next.run_valid = busy;
      res_next.run_slot = busy ? s : '0;
      res_next.time_now = current_time;
      current_time_next = current_time + 1'b1;
      cpu_slot_next = s;
      cpu_busy_next = busy;
      quantum_used_next = qu;
      if (busy) begin
        rb = remaining_burst[s] - 16'd1;
        remaining_burst_next[s] = rb;
        qu = qu + 8'd1;
        quantum_used_next = qu;
        if (rb == 16'd0) begin
          res_next.done_valid = 1'b1;
          res_next.done_slot = s;
          res_next.done_end_time = current_time + 1'b1;
          res_next.done_wait = wait_count[s];
          res_next.done_first_run = (!has_run[s]) ? current_time : first_run_time[s];
          cpu_busy_next = 1'b0;
          quantum_used_next = '0;
        end else if (qu == quantum) begin
          requeue = 1'b1;
          cpu_busy_next = 1'b0;
          quantum_used_next = '0;
        end
      end
      for (int i = 0; i < P; i++) begin
        if (waiting[i]) wait_count_next[i] = wait_count[i] + 1'b1;
      end
      in_ready_next = waiting;
      if (requeue) begin
        lv = slot_level[s];
        // the queue of lv may just have been drained by the pop above
        if (level_nonempty_next[lv]) next_in_level_next[level_tail[lv]] = s;
        else begin
          level_head_next[lv] = s;
          level_nonempty_next[lv] = 1'b1;
        end
        level_tail_next[lv] = s;
        in_ready_next[s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      cpu_busy <= 1'b0;
      cpu_slot <= '0;
      quantum_used <= '0;
      in_ready <= '0;
      level_nonempty <= '0;
      for (int i = 0; i < L; i++) begin
        level_head[i] <= '0;
        level_tail[i] <= '0;
      end
      res_valid <= 1'b0;
    end else begin
      res_valid <= go && word.operation == mlq_pkg::OP_TICK;
      if (go) begin
        current_time <= current_time_next;
        cpu_busy <= cpu_busy_next;
        cpu_slot <= cpu_slot_next;
        quantum_used <= quantum_used_next;
        in_ready <= in_ready_next;
        level_nonempty <= level_nonempty_next;
        level_head <= level_head_next;
        level_tail <= level_tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      remaining_burst <= remaining_burst_next;
      wait_count <= wait_count_next;
      first_run_time <= first_run_time_next;
      has_run <= has_run_next;
      slot_level <= slot_level_next;
      next_in_level <= next_in_level_next;
      res <= res_next;
    end
  end

  assign cpu_busy_o = cpu_busy;
endmodule
